>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while in reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while in reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/tcpid_pkg.sv
// ----------------------------------------------------------------------------
// tcpid_pkg
// Types and constants of the three-channel incremental PID core.
// ----------------------------------------------------------------------------
package tcpid_pkg;

  localparam int IDX_W        = 2;
  localparam int SPEED_W      = 16;
  localparam int GAIN_W       = 16;
  localparam int ERR_W        = 18;
  localparam int DRIVE_W      = 17;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int TARGET_COUNT = 3;

  localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 17'sd40960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_TARGET_0 = 3'd3,
    REG_TARGET_1 = 3'd4,
    REG_TARGET_2 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [GAIN_W-1:0]  gain_p;
    logic        [GAIN_W-1:0]  gain_i;
    logic        [GAIN_W-1:0]  gain_d;
    logic signed [SPEED_W-1:0] target_0;
    logic signed [SPEED_W-1:0] target_1;
    logic signed [SPEED_W-1:0] target_2;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   e_prev;
    logic signed [ERR_W-1:0]   e_old;
    logic signed [DRIVE_W-1:0] drive_prev;
  } chan_state_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      stopped;
    logic                      update;
    logic signed [ERR_W-1:0]   e_new;
  } calc_res_t;

endpackage

>>> rtl/tcpid_in_if.sv
// ----------------------------------------------------------------------------
// tcpid_in_if
// Measurement channel: motor index and measured speed.
// ----------------------------------------------------------------------------
interface tcpid_in_if;
  import tcpid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [IDX_W-1:0]   motor_index;
  logic signed [SPEED_W-1:0] measured_speed;

  modport source (output valid, output motor_index, output measured_speed, input ready);
  modport sink   (input valid, input motor_index, input measured_speed, output ready);
endinterface

>>> rtl/tcpid_out_if.sv
// ----------------------------------------------------------------------------
// tcpid_out_if
// Result channel: clamped drive and stop flag.
// ----------------------------------------------------------------------------
interface tcpid_out_if;
  import tcpid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_value;
  logic                      stopped;

  modport source (output valid, output drive_value, output stopped, input ready);
  modport sink   (input valid, input drive_value, input stopped, output ready);
endinterface

>>> rtl/tcpid_cfg_if.sv
// ----------------------------------------------------------------------------
// tcpid_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcpid_cfg_if;
  import tcpid_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tcpid_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcpid_cfg_regs
// Gain and target registers, written through the config channel.
// ----------------------------------------------------------------------------
module tcpid_cfg_regs
  import tcpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_GAIN_P:   cfg_nxt.gain_p   = wr_data;
        REG_GAIN_I:   cfg_nxt.gain_i   = wr_data;
        REG_GAIN_D:   cfg_nxt.gain_d   = wr_data;
        REG_TARGET_0: cfg_nxt.target_0 = $signed(wr_data);
        REG_TARGET_1: cfg_nxt.target_1 = $signed(wr_data);
        REG_TARGET_2: cfg_nxt.target_2 = $signed(wr_data);
        default:      cfg_nxt = cfg_r;   // index past the map: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/tcpid_calc.sv
// ----------------------------------------------------------------------------
// tcpid_calc
// Velocity-form PID update for one measurement, with drive clamp.
// ----------------------------------------------------------------------------
module tcpid_calc
  import tcpid_pkg::*;
(
  input  cfg_t                      cfg,
  input  logic                      chan_ok,
  input  logic        [IDX_W-1:0]   idx,
  input  logic signed [SPEED_W-1:0] meas,
  input  chan_state_t               st,
  output calc_res_t                 res
);

  logic signed [SPEED_W-1:0] tgt;
  logic signed [SPEED_W:0]   err17;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W:0]     d1;     // e - e1
  logic signed [ERR_W+1:0]   d2;     // e - 2*e1 + e2
  logic signed [35:0]        prod_p;
  logic signed [34:0]        prod_i;
  logic signed [36:0]        prod_d;
  logic signed [38:0]        total;

  always_comb begin
    case (idx)
      2'd0:    tgt = cfg.target_0;
      2'd1:    tgt = cfg.target_1;
      2'd2:    tgt = cfg.target_2;
      default: tgt = '0;
    endcase
  end

  assign err17 = {tgt[SPEED_W-1], tgt} - {meas[SPEED_W-1], meas};
  assign err   = {err17[SPEED_W], err17};
  assign d1    = {err[ERR_W-1], err} - {st.e_prev[ERR_W-1], st.e_prev};
  assign d2    = {{2{err[ERR_W-1]}}, err} - {st.e_prev[ERR_W-1], st.e_prev, 1'b0}
               + {{2{st.e_old[ERR_W-1]}}, st.e_old};

  // Q8.8 gain times Q.4 error lands exactly in Q.12
  assign prod_p = $signed({1'b0, cfg.gain_p}) * d1;
  assign prod_i = $signed({1'b0, cfg.gain_i}) * err;
  assign prod_d = $signed({1'b0, cfg.gain_d}) * d2;

  assign total = {{3{prod_p[35]}}, prod_p} + {{4{prod_i[34]}}, prod_i}
               + {{2{prod_d[36]}}, prod_d}
               + {{22{st.drive_prev[DRIVE_W-1]}}, st.drive_prev};

  always_comb begin
    res.e_new = err;
    if (!chan_ok) begin
      res.drive   = '0;
      res.stopped = 1'b0;
      res.update  = 1'b0;
    end else if (tgt == '0) begin
      res.drive   = '0;
      res.stopped = 1'b1;
      res.update  = 1'b0;
    end else begin
      res.stopped = 1'b0;
      res.update  = 1'b1;
      if (total > 39'(DRIVE_LIMIT)) begin
        res.drive = DRIVE_LIMIT;
      end else if (total < -39'(DRIVE_LIMIT)) begin
        res.drive = -DRIVE_LIMIT;
      end else begin
        res.drive = total[DRIVE_W-1:0];
      end
    end
  end

endmodule

>>> rtl/three_channel_incremental_pid_core.sv
// ----------------------------------------------------------------------------
// three_channel_incremental_pid_core
// Incremental PID speed loop for up to three motors, one result per sample.
// ----------------------------------------------------------------------------
//   channel  dir  payload                          transfer
//   in_bus   in   motor_index, measured_speed      valid & ready
//   out_bus  out  drive_value, stopped             valid & ready
//   cfg_bus  in   index, data (register write)     valid & ready, ready tied high
//
// A sample passes from input transfer to result through the input register,
// then one pass through the three gain multipliers, adder and clamp into
// the result register. One sample per cycle is sustained unless out_bus stalls;
// per-motor state is written with the result, so a sample right behind it
// sees it. Reset clears gains, targets and motor state. A stalled result holds
// the result register and the input register keeps one sample behind it.
// ----------------------------------------------------------------------------
module three_channel_incremental_pid_core
  import tcpid_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input logic       clk,
  input logic       rst_n,
  tcpid_in_if.sink   in_bus,
  tcpid_out_if.source out_bus,
  tcpid_cfg_if.sink  cfg_bus
);

  localparam int NUM_ACTIVE = (NUM_CHANNELS < TARGET_COUNT) ? NUM_CHANNELS : TARGET_COUNT;
  localparam int CH_W       = (NUM_ACTIVE > 1) ? $clog2(NUM_ACTIVE) : 1;
  localparam logic [IDX_W:0] CH_LIMIT = (IDX_W+1)'(NUM_ACTIVE);

  cfg_t        cfg;
  chan_state_t st_r [NUM_ACTIVE];
  chan_state_t st_sel;
  calc_res_t   res;

  logic                      in_v_r;
  logic        [IDX_W-1:0]   idx_r;
  logic signed [SPEED_W-1:0] meas_r;
  logic                      out_v_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      stop_r;
  logic                      chan_ok;
  logic [CH_W-1:0]           ch;
  logic                      advance;
  logic                      take_in;

  assign cfg_bus.ready = 1'b1;

  tcpid_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_bus.valid),
    .wr_idx  (cfg_bus.index),
    .wr_data (cfg_bus.data),
    .cfg     (cfg)
  );

  assign advance = !out_v_r || out_bus.ready;
  assign take_in = !in_v_r || advance;
  assign in_bus.ready = take_in;

  assign chan_ok = {1'b0, idx_r} < CH_LIMIT;
  assign ch      = CH_W'(idx_r);
  assign st_sel  = chan_ok ? st_r[ch] : '0;

  tcpid_calc u_calc (
    .cfg     (cfg),
    .chan_ok (chan_ok),
    .idx     (idx_r),
    .meas    (meas_r),
    .st      (st_sel),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < NUM_ACTIVE; i++) begin
        st_r[i] <= '0;
      end
    end else begin
      if (take_in) begin
        in_v_r <= in_bus.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (advance && in_v_r && res.update) begin
        st_r[ch] <= '{e_prev: res.e_new, e_old: st_sel.e_prev, drive_prev: res.drive};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      idx_r  <= in_bus.motor_index;
      meas_r <= in_bus.measured_speed;
    end
    if (advance && in_v_r) begin
      drive_r <= res.drive;
      stop_r  <= res.stopped;
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.drive_value = drive_r;
  assign out_bus.stopped     = stop_r;

endmodule

>>> rtl/tcpid_checker.sv
// ----------------------------------------------------------------------------
// tcpid_checker
// Port-level checks on the result channel of the PID core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcpid_checker
  import tcpid_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] out_drive,
  input logic                      out_stopped
);

  logic in_window;
  logic stalled;

  assign in_window = (out_drive <= DRIVE_LIMIT) && (out_drive >= -DRIVE_LIMIT);
  assign stalled   = out_valid && !out_ready;

  // a stopped motor never drives
  `AST_IMPLY(a_stop_zero, clk, rst_n, out_valid && out_stopped, out_drive == '0)
  // drive never leaves the clamp window
  `AST_IMPLY(a_drive_range, clk, rst_n, out_valid, in_window)
  // reset empties the result stage
  `AST_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  // stalled result holds
  `AST_NEXT(a_hold, clk, rst_n, stalled, out_valid && $stable({out_drive, out_stopped}))

endmodule

bind three_channel_incremental_pid_core tcpid_checker u_tcpid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_drive   (out_bus.drive_value),
  .out_stopped (out_bus.stopped)
);
